[src/rwcs_pkg.sv]
// rwcs_pkg: shared types, widths and helpers for the wall column setup unit
// no dependencies; imported by the top unit and the checker
package rwcs_pkg;

    localparam int SUBPIXEL_BITS = 8;
    localparam int COS_FRAC      = 14;
    localparam int STEP_FRAC     = 16;

    // field widths
    localparam int COL_W   = 12;
    localparam int DIST_W  = 24;
    localparam int COS_W   = 15;
    localparam int ALONG_W = 24;
    localparam int TEXI_W  = 3;
    localparam int TX_W    = 10;
    localparam int POS_W   = 20;
    localparam int ROW_W   = 12;
    localparam int STEP_W  = 26;

    // configuration register widths
    localparam int SCR_W  = 13;
    localparam int TILE_W = 11;
    localparam int PROJ_W = 16;
    localparam int TEXD_W = 11;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PROJ_DIST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT    = 3'd5;

    localparam logic [SCR_W-1:0]  RST_SCREEN_WIDTH  = 13'd1280;
    localparam logic [SCR_W-1:0]  RST_SCREEN_HEIGHT = 13'd720;
    localparam logic [TILE_W-1:0] RST_TILE_SIZE     = 11'd64;
    localparam logic [PROJ_W-1:0] RST_PROJ_DIST     = 16'd1108;
    localparam logic [TEXD_W-1:0] RST_TEX_WIDTH     = 11'd64;
    localparam logic [TEXD_W-1:0] RST_TEX_HEIGHT    = 11'd64;

    localparam logic [TEXI_W-1:0] TEX_NORTH = 3'd0;
    localparam logic [TEXI_W-1:0] TEX_SOUTH = 3'd1;
    localparam logic [TEXI_W-1:0] TEX_EAST  = 3'd2;
    localparam logic [TEXI_W-1:0] TEX_WEST  = 3'd3;
    localparam logic [TEXI_W-1:0] TEX_DOOR  = 3'd4;

    // derived arithmetic widths
    localparam int ZD_RAW   = ((1 << SUBPIXEL_BITS) + 5) / 10;
    localparam int ZERO_DIST_RAW = (ZD_RAW == 0) ? 1 : ZD_RAW;
    localparam int PROD_W   = DIST_W + COS_W;
    localparam int CORR_W   = PROD_W - COS_FRAC;
    localparam int TP_W     = TILE_W + PROJ_W;
    localparam int NUMH_W   = TP_W + SUBPIXEL_BITS;
    localparam int AINT_W   = ALONG_W - SUBPIXEL_BITS;
    localparam int SPAN_W   = TILE_W + SUBPIXEL_BITS;
    localparam int TXM_W    = SPAN_W + TEXD_W;
    localparam int TXQ_W    = TEXD_W;
    localparam int RNUM_W   = TEXD_W + STEP_FRAC;
    localparam int SPOS_W   = POS_W + 1;
    localparam int M2_W     = POS_W + TEXD_W;
    localparam int YNUM_W   = M2_W + STEP_FRAC;

    // pipeline latencies, in register stages
    localparam int LAT_MOD   = AINT_W;
    localparam int LAT_H     = POS_W;
    localparam int LAT_TX    = TXQ_W;
    localparam int LAT_RATIO = RNUM_W;
    localparam int ST_H      = 1 + LAT_H;
    localparam int ST_TXM    = 1 + LAT_MOD + 1;
    localparam int ST_TX     = ST_TXM + LAT_TX;
    localparam int ST_G2     = ST_H + 2;
    localparam int DEPTH     = ST_G2 + LAT_RATIO;

    localparam logic [POS_W-1:0]  H_MAX    = '1;
    localparam logic [STEP_W-1:0] STEP_MAX = '1;
    localparam logic [TX_W-1:0]   TX_MAX   = '1;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 136;

    typedef struct packed {
        logic [6:0]         pad;
        logic               door_hit;
        logic               facing_left;
        logic               facing_right;
        logic               facing_down;
        logic               facing_up;
        logic               hit_vertical;
        logic [ALONG_W-1:0] hit_along;
        logic [COS_W-1:0]   cos_relative;
        logic [DIST_W-1:0]  ray_distance;
        logic [COL_W-1:0]   column;
    } t_ray;

    typedef struct packed {
        logic [5:0]        pad;
        logic [STEP_W-1:0] texture_y_start;
        logic [STEP_W-1:0] texture_step;
        logic [ROW_W-1:0]  last_row;
        logic [ROW_W-1:0]  first_row;
        logic              column_visible;
        logic [POS_W-1:0]  wall_bottom;
        logic [POS_W-1:0]  wall_top;
        logic [TX_W-1:0]   texture_x;
        logic [TEXI_W-1:0] texture_index;
    } t_result;

    typedef struct packed {
        logic             h_zero;
        logic             vis;
        logic [ROW_W-1:0] last_row;
        logic [ROW_W-1:0] first_row;
        logic [POS_W-1:0] bottom;
        logic [POS_W-1:0] top;
    } t_geo;

    function automatic logic [TEXI_W-1:0] pick_texture(
        input logic vert, input logic up, input logic down,
        input logic right, input logic left, input logic door);
        logic [TEXI_W-1:0] t;
        t = TEX_NORTH;
        if (!vert) begin
            if (up) t = door ? TEX_DOOR : TEX_NORTH;
            else if (down) t = door ? TEX_DOOR : TEX_SOUTH;
        end else if (right || left) begin
            if (door) t = TEX_DOOR;
            else t = right ? TEX_EAST : TEX_WEST;
        end
        return t;
    endfunction

endpackage

[src/rwcs_udiv.sv]
// rwcs_udiv: pipelined restoring divider, one quotient bit per register stage
// depends on nothing; the caller keeps num >> QW below den
module rwcs_udiv #(
    parameter int NW = 16,
    parameter int DW = 8,
    parameter int QW = 8
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo,
    output logic [DW-1:0] o_rem
);
    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_quo [QW];
    logic [NW-1:0] r_num [QW];
    logic [DW-1:0] r_den [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [NW-1:0] num_in;
        logic [DW:0]   trial;
        logic          ge;

        if (g == 0) begin : g_first
            assign rem_in = DW'(i_num >> QW);
            assign den_in = i_den;
            assign quo_in = '0;
            assign num_in = i_num;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign den_in = r_den[g-1];
            assign quo_in = r_quo[g-1];
            assign num_in = r_num[g-1];
        end

        assign trial = {rem_in, num_in[QW-1-g]};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
                r_quo[g] <= QW'({quo_in, ge});
                r_num[g] <= num_in;
                r_den[g] <= den_in;
            end
        end
    end

    assign o_quo = r_quo[QW-1];
    assign o_rem = r_rem[QW-1];
endmodule

[src/rwcs_delay.sv]
// rwcs_delay: enabled shift line that keeps side data in step with the dividers
// depends on nothing
module rwcs_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);
    logic [W-1:0] r_tap [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < N; k++) r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_q = r_tap[N-1];
endmodule

[src/raycast_wall_column_setup_unit.sv]
// raycast_wall_column_setup_unit: per-column wall strip setup for a ray caster
// depends on rwcs_pkg, rwcs_udiv and rwcs_delay
//
// Usage: one ray item per screen column enters on the s-side stream
// (i_s_tvalid / o_s_tready / i_s_tdata); one result item per ray leaves on
// the m-side stream (o_m_tvalid / i_m_tready / o_m_tdata) in the same order.
// Six setup registers are written on the cfg channel (index 0..5, other
// indexes ignored); o_cfg_ready is always high, writes belong between frames.
// Throughput: one item per cycle while the output is not stalled. Results pass
// through the input multiply stage, the strip height divider (20 stages), two
// geometry stages, the texture step and start dividers (27 stages each, side
// by side) and the output register.
// Reset: synchronous, active low; empties the pipeline and output stage and
// loads the default screen 1280x720, tile 64, projection 1108, textures 64x64.
// Stall: the output register is backed by a one-item skid stage; while the
// skid stage is full the whole pipeline holds and o_s_tready is low, so no
// item is lost or repeated.
module raycast_wall_column_setup_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // column, ray_distance, cos_relative, hit_along, hit_vertical, facing_up,
    // facing_down, facing_right, facing_left, door_hit, zero pad
    input  logic [rwcs_pkg::S_TDATA_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // texture_index, texture_x, wall_top, wall_bottom, column_visible,
    // first_row, last_row, texture_step, texture_y_start, zero pad
    output logic [rwcs_pkg::M_TDATA_W-1:0]      o_m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rwcs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rwcs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rwcs_pkg::*;

    logic [SCR_W-1:0]  r_screen_width, r_screen_height;
    logic [TILE_W-1:0] r_tile_size;
    logic [PROJ_W-1:0] r_proj_dist;
    logic [TEXD_W-1:0] r_tex_width, r_tex_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= RST_SCREEN_WIDTH;
            r_screen_height <= RST_SCREEN_HEIGHT;
            r_tile_size     <= RST_TILE_SIZE;
            r_proj_dist     <= RST_PROJ_DIST;
            r_tex_width     <= RST_TEX_WIDTH;
            r_tex_height    <= RST_TEX_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[SCR_W-1:0];
                REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[SCR_W-1:0];
                REG_TILE_SIZE:     r_tile_size     <= i_cfg_data[TILE_W-1:0];
                REG_PROJ_DIST:     r_proj_dist     <= i_cfg_data[PROJ_W-1:0];
                REG_TEX_WIDTH:     r_tex_width     <= i_cfg_data[TEXD_W-1:0];
                REG_TEX_HEIGHT:    r_tex_height    <= i_cfg_data[TEXD_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advance and valid tracking
    logic             r_skid_valid;
    logic             en;
    logic [DEPTH-1:0] r_vld;
    t_ray             ray;
    logic [DIST_W-1:0] dist0;

    assign en         = !r_skid_valid;
    assign o_s_tready = en;
    assign ray        = t_ray'(i_s_tdata);
    assign dist0      = (ray.ray_distance == '0) ? DIST_W'(ZERO_DIST_RAW) : ray.ray_distance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_s_tvalid};
        end
    end

    // stage 1: multiplies and texture choice
    logic [PROD_W-1:0]        r1_prod;
    logic [TP_W-1:0]          r1_tp;
    logic [AINT_W-1:0]        r1_along_int;
    logic [SUBPIXEL_BITS-1:0] r1_along_frac;
    logic [COL_W-1:0]         r1_col;
    logic [TEXI_W-1:0]        r1_tex;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_prod       <= PROD_W'(dist0) * PROD_W'(ray.cos_relative);
            r1_tp         <= TP_W'(r_tile_size) * TP_W'(r_proj_dist);
            r1_along_int  <= ray.hit_along[ALONG_W-1:SUBPIXEL_BITS];
            r1_along_frac <= ray.hit_along[SUBPIXEL_BITS-1:0];
            r1_col        <= ray.column;
            r1_tex        <= pick_texture(ray.hit_vertical, ray.facing_up, ray.facing_down,
                                          ray.facing_right, ray.facing_left, ray.door_hit);
        end
    end

    // strip height divider
    logic [CORR_W-1:0] corr;
    logic [NUMH_W-1:0] numh;
    logic              h_sat, h_zero, h_sat_d, h_zero_d;
    logic [POS_W-1:0]  h_quo;

    assign corr   = r1_prod[PROD_W-1:COS_FRAC];
    assign numh   = {r1_tp, {SUBPIXEL_BITS{1'b0}}};
    assign h_zero = (r1_tp == '0);
    assign h_sat  = (corr == '0) || ((numh >> POS_W) >= NUMH_W'(corr));

    rwcs_udiv #(.NW(NUMH_W), .DW(CORR_W), .QW(POS_W)) u_hdiv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ((h_sat || h_zero) ? '0 : numh),
        .i_den ((corr == '0) ? CORR_W'(1) : corr),
        .o_quo (h_quo),
        .o_rem ()
    );

    rwcs_delay #(.W(2), .N(LAT_H)) u_hflag_dly (
        .i_clk (i_clk), .i_en (en), .i_d ({h_sat, h_zero}), .o_q ({h_sat_d, h_zero_d})
    );

    // texture x: fractional tile position, then scaled by texture width
    logic [TILE_W-1:0]        tile_rem;
    logic [SUBPIXEL_BITS-1:0] frac_d;
    logic [TXM_W-1:0]         r_txm;
    logic [TXQ_W-1:0]         tx_quo, tx_quo_d;

    rwcs_udiv #(.NW(AINT_W), .DW(TILE_W), .QW(LAT_MOD)) u_moddiv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r1_along_int),
        .i_den ((r_tile_size == '0) ? TILE_W'(1) : r_tile_size),
        .o_quo (),
        .o_rem (tile_rem)
    );

    rwcs_delay #(.W(SUBPIXEL_BITS), .N(LAT_MOD)) u_frac_dly (
        .i_clk (i_clk), .i_en (en), .i_d (r1_along_frac), .o_q (frac_d)
    );

    always_ff @(posedge i_clk) begin
        if (en) r_txm <= TXM_W'({tile_rem, frac_d}) * TXM_W'(r_tex_width);
    end

    rwcs_udiv #(.NW(TXM_W), .DW(SPAN_W), .QW(TXQ_W)) u_txdiv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_txm),
        .i_den ({r_tile_size, {SUBPIXEL_BITS{1'b0}}}),
        .o_quo (tx_quo),
        .o_rem ()
    );

    rwcs_delay #(.W(TXQ_W), .N(DEPTH - ST_TX)) u_tx_dly (
        .i_clk (i_clk), .i_en (en), .i_d (tx_quo), .o_q (tx_quo_d)
    );

    // strip geometry
    logic [COL_W-1:0]         col_d;
    logic [POS_W-1:0]         h;
    logic signed [SPOS_W-1:0] s_half, s_hh, s_top, s_bot, s_first, s_last_a, s_shm1, s_last;
    logic [POS_W-1:0]         d_rows;
    logic                     vis;

    rwcs_delay #(.W(COL_W), .N(LAT_H)) u_col_dly (
        .i_clk (i_clk), .i_en (en), .i_d (r1_col), .o_q (col_d)
    );

    assign h        = h_zero_d ? '0 : (h_sat_d ? H_MAX : h_quo);
    assign s_half   = signed'(SPOS_W'(r_screen_height >> 1));
    assign s_hh     = signed'(SPOS_W'(h >> 1));
    assign s_top    = s_half - s_hh;
    assign s_bot    = s_half + s_hh;
    assign s_first  = s_top[SPOS_W-1] ? '0 : s_top;
    assign s_last_a = s_bot - SPOS_W'(1);
    assign s_shm1   = signed'(SPOS_W'(r_screen_height)) - SPOS_W'(1);
    assign s_last   = (s_last_a < s_shm1) ? s_last_a : s_shm1;
    assign vis      = (SCR_W'(col_d) < r_screen_width) && (s_first <= s_last);
    assign d_rows   = s_top[SPOS_W-1] ? POS_W'(-s_top) : '0;

    t_geo             r22_geo, r23_geo, geo_d;
    logic [POS_W-1:0] r22_h, r22_d, r23_h;
    logic [M2_W-1:0]  r23_m2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r22_geo.h_zero    <= (h == '0);
            r22_geo.vis       <= vis;
            r22_geo.last_row  <= s_last[ROW_W-1:0];
            r22_geo.first_row <= s_first[ROW_W-1:0];
            r22_geo.bottom    <= s_bot[POS_W-1:0];
            r22_geo.top       <= s_top[POS_W-1:0];
            r22_h             <= h;
            r22_d             <= d_rows;
            r23_geo           <= r22_geo;
            r23_h             <= r22_h;
            r23_m2            <= M2_W'(r22_d) * M2_W'(r_tex_height);
        end
    end

    // texture step and start dividers
    logic [POS_W-1:0]  den_h;
    logic [RNUM_W-1:0] step_quo, ys_quo;

    assign den_h = (r23_h == '0) ? POS_W'(1) : r23_h;

    rwcs_udiv #(.NW(RNUM_W), .DW(POS_W), .QW(LAT_RATIO)) u_stepdiv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({r_tex_height, {STEP_FRAC{1'b0}}}),
        .i_den (den_h),
        .o_quo (step_quo),
        .o_rem ()
    );

    rwcs_udiv #(.NW(YNUM_W), .DW(POS_W), .QW(LAT_RATIO)) u_ysdiv (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({r23_m2, {STEP_FRAC{1'b0}}}),
        .i_den (den_h),
        .o_quo (ys_quo),
        .o_rem ()
    );

    rwcs_delay #(.W($bits(t_geo)), .N(LAT_RATIO)) u_geo_dly (
        .i_clk (i_clk), .i_en (en), .i_d (r23_geo), .o_q (geo_d)
    );

    logic [TEXI_W-1:0] tex_d;

    rwcs_delay #(.W(TEXI_W), .N(DEPTH - 1)) u_tex_dly (
        .i_clk (i_clk), .i_en (en), .i_d (r1_tex), .o_q (tex_d)
    );

    // result assembly at the pipeline tail
    t_result res;

    always_comb begin
        res                 = '0;
        res.texture_index   = tex_d;
        if (r_tile_size == '0) res.texture_x = '0;
        else if (tx_quo_d > TXQ_W'(TX_MAX)) res.texture_x = TX_MAX;
        else res.texture_x = tx_quo_d[TX_W-1:0];
        res.wall_top        = geo_d.top;
        res.wall_bottom     = geo_d.bottom;
        res.column_visible  = geo_d.vis;
        if (geo_d.h_zero) res.texture_step = '0;
        else if (step_quo > RNUM_W'(STEP_MAX)) res.texture_step = STEP_MAX;
        else res.texture_step = step_quo[STEP_W-1:0];
        if (geo_d.vis) begin
            res.first_row = geo_d.first_row;
            res.last_row  = geo_d.last_row;
            res.texture_y_start = (ys_quo > RNUM_W'(STEP_MAX)) ? STEP_MAX : ys_quo[STEP_W-1:0];
        end
    end

    // output register with skid stage
    t_result r_out, r_skid;
    logic    r_out_valid;
    logic    take;

    assign take = r_vld[DEPTH-1] && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            r_out_valid  <= r_skid_valid || take;
            r_skid_valid <= 1'b0;
        end else if (take) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (take) begin
            r_skid <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;
endmodule

[src/rwcs_checker.sv]
// rwcs_checker: port-level checks for the wall column setup unit
// depends on rwcs_pkg; bound to raycast_wall_column_setup_unit below
module rwcs_port_checks (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [rwcs_pkg::M_TDATA_W-1:0]  o_m_tdata
);
    import rwcs_pkg::*;

    t_result res;
    assign res = t_result'(o_m_tdata);

    // a stalled result item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result item changed while stalled");

    // no result item is valid in the cycle after a reset cycle
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result item right after reset");

    // hidden columns carry no row span and no texture start
    a_hidden: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !res.column_visible |->
            res.first_row == '0 && res.last_row == '0 && res.texture_y_start == '0)
        else $error("hidden column with row data");

    a_tex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> res.texture_index <= TEX_DOOR)
        else $error("texture index out of range");
endmodule

bind raycast_wall_column_setup_unit rwcs_port_checks u_rwcs_checker (.*);
